// File: rtl/fbfha_pkg.sv
// ----------------------------------------------------------------------------
// fbfha_pkg: shared types and constants
// Status codes, commands, defaults and register indexes for the allocator.
// ----------------------------------------------------------------------------
package fbfha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int ADDR_BITS_DEF    = 32;

  localparam int WORD_W = 32;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

endpackage

// File: rtl/fbfha_if.sv
// ----------------------------------------------------------------------------
// fbfha channel interfaces
// Valid/ready channels for command, result and configuration beats.
// ----------------------------------------------------------------------------
interface fbfha_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] request_size;
  logic [31:0] payload_addr;
  modport source (output valid, cmd, request_size, payload_addr, input ready);
  modport sink   (input valid, cmd, request_size, payload_addr, output ready);
endinterface

interface fbfha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [1:0]  status;
  logic [31:0] segment_bytes;
  logic [31:0] free_bytes;
  modport source (output valid, result_addr, status, segment_bytes, free_bytes,
                  input ready);
  modport sink   (input valid, result_addr, status, segment_bytes, free_bytes,
                  output ready);
endinterface

interface fbfha_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/first_best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_best_fit_heap_allocator
// Address-ordered block table heap allocator with first/best fit and merge.
// ----------------------------------------------------------------------------
// The block allocator works on one command at a time. The block table sits in
// one synchronous memory that has a single read port with a registered read.
// A command scans the live entries, one read and one check per entry. First
// fit stops at the first hit; best fit scans on to the end, and free on to
// the match or the end. A split then moves the tail of the table up by one
// entry, and a merge with one or both neighbors moves it down over the
// removed entries, one read and one write per entry moved. The next command
// may be accepted while a result beat still waits in the output register.
// That command runs to its end and then holds until the register is free.
module first_best_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = fbfha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = fbfha_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = fbfha_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fbfha_in_if.sink    in_ch,
  fbfha_out_if.source out_ch,
  fbfha_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam int EW = 65;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [33:0] HB34 = 34'(HEADER_BYTES);
  localparam logic [31:0] HB32 = 32'(HEADER_BYTES);
  localparam logic [33:0] ACAP = (ADDR_BITS >= 32) ? 34'h0FFFFFFFF
                                 : ((34'd1 << ADDR_BITS) - 34'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCHK, S_DEC, S_NRD, S_NCHK, S_PRD, S_PCHK,
    S_FIN, S_WA, S_MRD, S_MWR, S_WB, S_RESP
  } st_t;

  // entry: {free, size, offset}
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  st_t                 st_r;
  logic                fit_r;
  logic [31:0]         lim_r;
  logic [CW-1:0]       cnt_r, idx_r, pick_r;
  logic                found_r, pfree_r;
  logic [31:0]         psize_r, poff_r;
  logic                cmd_r;
  logic [31:0]         req_r, pa_r;
  logic [31:0]         top_r, ftot_r;
  logic [31:0]         raddr_r;
  fbfha_pkg::status_t  stat_r;
  // pending writes and table move
  logic [CW-1:0]       wa_addr_r;
  logic [EW-1:0]       wa_data_r;
  logic                wb_en_r;
  logic [CW-1:0]       wb_addr_r;
  logic [EW-1:0]       wb_data_r;
  logic                mv_en_r, mv_up_r;
  logic [CW-1:0]       mv_src_r, mv_end_r;
  logic [1:0]          mv_k_r;
  // free: merged block
  logic [31:0]         cur_size_r, cur_off_r;
  logic [1:0]          rm_k_r;
  // output register
  logic                ovld_r;
  logic [31:0]         oaddr_r, oseg_r, ofree_r;
  fbfha_pkg::status_t  ostat_r;

  // memory port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  logic        e_free;
  logic [31:0] e_size, e_off;
  assign e_free = rd_data_r[64];
  assign e_size = rd_data_r[63:32];
  assign e_off  = rd_data_r[31:0];

  logic [33:0]   need;
  logic [33:0]   cap;
  logic [31:0]   split_rest;
  logic [CW-1:0] mv_dst;
  logic          out_load;
  assign need       = {2'b0, top_r} + HB34 + {2'b0, req_r};
  assign cap        = ({2'b0, lim_r} < ACAP) ? {2'b0, lim_r} : ACAP;
  assign split_rest = psize_r - req_r - HB32;
  assign mv_dst     = mv_up_r ? mv_src_r + CW'(1) : mv_src_r - CW'(mv_k_r);
  assign out_load   = (st_r == S_RESP) && (!ovld_r || out_ch.ready);

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovld_r;
  assign out_ch.result_addr   = oaddr_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.segment_bytes = oseg_r;
  assign out_ch.free_bytes    = ofree_r;

  // read address and write port selection
  always_comb begin
    rd_addr = idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = wa_addr_r[IW-1:0];
    wr_data = wa_data_r;
    case (st_r)
      S_WA:  wr_en = 1'b1;
      S_MRD: rd_addr = mv_src_r[IW-1:0];
      S_MWR: begin
        wr_en   = 1'b1;
        wr_addr = mv_dst[IW-1:0];
        wr_data = rd_data_r;
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = wb_addr_r[IW-1:0];
        wr_data = wb_data_r;
      end
      default: ;
    endcase
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fit_r  <= 1'b0;
      lim_r  <= 32'hFFFFFFFF;
      cnt_r  <= '0;
      top_r  <= '0;
      ftot_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          fbfha_pkg::CFG_FIT_MODE:   fit_r <= cfg_ch.data[0];
          fbfha_pkg::CFG_HEAP_LIMIT: lim_r <= cfg_ch.data;
          default: ;
        endcase
      end
      ovld_r <= out_load || (ovld_r && !out_ch.ready);
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          cmd_r   <= in_ch.cmd;
          req_r   <= in_ch.request_size;
          pa_r    <= in_ch.payload_addr;
          idx_r   <= '0;
          found_r <= 1'b0;
          raddr_r <= '0;
          stat_r  <= fbfha_pkg::ST_OK;
          wb_en_r <= 1'b0;
          mv_en_r <= 1'b0;
          rm_k_r  <= '0;
          if (in_ch.cmd == fbfha_pkg::CMD_FREE && in_ch.payload_addr == '0)
            st_r <= S_RESP;
          else
            st_r <= S_SRD;
        end
        // scan: issue read or finish
        S_SRD: begin
          if (idx_r >= cnt_r) st_r <= S_DEC;
          else st_r <= S_SCHK;
        end
        S_SCHK: begin
          if (cmd_r == fbfha_pkg::CMD_ALLOC) begin
            if (e_free && e_size >= req_r &&
                (!found_r || (fit_r && e_size < psize_r))) begin
              found_r <= 1'b1;
              pick_r  <= idx_r;
              psize_r <= e_size;
              poff_r  <= e_off;
            end
            if (!fit_r && e_free && e_size >= req_r) st_r <= S_DEC;
            else begin
              idx_r <= idx_r + CW'(1);
              st_r  <= S_SRD;
            end
          end else if ({2'b0, e_off} + HB34 == {2'b0, pa_r}) begin
            found_r <= 1'b1;
            pick_r  <= idx_r;
            psize_r <= e_size;
            poff_r  <= e_off;
            pfree_r <= e_free;
            st_r    <= S_DEC;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r  <= S_SRD;
          end
        end
        // decide after scan
        S_DEC: begin
          if (cmd_r == fbfha_pkg::CMD_ALLOC) begin
            if (found_r) begin
              raddr_r   <= poff_r + HB32;
              wa_addr_r <= pick_r;
              if ({2'b0, psize_r} > {2'b0, req_r} + HB34 && cnt_r < MAXC) begin
                // split, tail becomes a free entry after the pick
                ftot_r    <= ftot_r - (psize_r + HB32) + (split_rest + HB32);
                wa_data_r <= {1'b0, req_r, poff_r};
                wb_en_r   <= 1'b1;
                wb_addr_r <= pick_r + CW'(1);
                wb_data_r <= {1'b1, split_rest, poff_r + HB32 + req_r};
                mv_en_r   <= (pick_r + CW'(1) < cnt_r);
                mv_up_r   <= 1'b1;
                mv_src_r  <= cnt_r - CW'(1);
                mv_end_r  <= pick_r + CW'(1);
                mv_k_r    <= 2'd1;
                cnt_r     <= cnt_r + CW'(1);
              end else begin
                ftot_r    <= ftot_r - (psize_r + HB32);
                wa_data_r <= {1'b0, psize_r, poff_r};
              end
              st_r <= S_WA;
            end else if (need > cap) begin
              stat_r <= fbfha_pkg::ST_LIMIT;
              st_r   <= S_RESP;
            end else if (cnt_r >= MAXC) begin
              stat_r <= fbfha_pkg::ST_FULL;
              st_r   <= S_RESP;
            end else begin
              // grow the segment at its top
              raddr_r   <= top_r + HB32;
              top_r     <= need[31:0];
              wa_addr_r <= cnt_r;
              wa_data_r <= {1'b0, req_r, top_r};
              cnt_r     <= cnt_r + CW'(1);
              st_r      <= S_WA;
            end
          end else begin
            if (!found_r || pfree_r) begin
              stat_r <= fbfha_pkg::ST_UNKNOWN;
              st_r   <= S_RESP;
            end else begin
              ftot_r     <= ftot_r + psize_r + HB32;
              cur_size_r <= psize_r;
              cur_off_r  <= poff_r;
              wa_addr_r  <= pick_r;
              if (pick_r + CW'(1) < cnt_r) begin
                idx_r <= pick_r + CW'(1);
                st_r  <= S_NRD;
              end else if (pick_r != '0) begin
                idx_r <= pick_r - CW'(1);
                st_r  <= S_PRD;
              end else st_r <= S_FIN;
            end
          end
        end
        // free: next neighbor
        S_NRD: st_r <= S_NCHK;
        S_NCHK: begin
          if (e_free) begin
            cur_size_r <= cur_size_r + HB32 + e_size;
            rm_k_r     <= 2'd1;
          end
          if (pick_r != '0) begin
            idx_r <= pick_r - CW'(1);
            st_r  <= S_PRD;
          end else st_r <= S_FIN;
        end
        // free: previous neighbor
        S_PRD: st_r <= S_PCHK;
        S_PCHK: begin
          if (e_free) begin
            cur_size_r <= e_size + HB32 + cur_size_r;
            cur_off_r  <= e_off;
            wa_addr_r  <= pick_r - CW'(1);
            rm_k_r     <= rm_k_r + 2'd1;
          end
          st_r <= S_FIN;
        end
        // free: merged entry and move the tail down over removed entries
        S_FIN: begin
          wa_data_r <= {1'b1, cur_size_r, cur_off_r};
          cnt_r     <= cnt_r - CW'(rm_k_r);
          mv_en_r   <= (rm_k_r != 2'd0) &&
                       (wa_addr_r + CW'(1) + CW'(rm_k_r) < cnt_r);
          mv_up_r   <= 1'b0;
          mv_src_r  <= wa_addr_r + CW'(1) + CW'(rm_k_r);
          mv_end_r  <= cnt_r - CW'(1);
          mv_k_r    <= rm_k_r;
          st_r      <= S_WA;
        end
        S_WA: begin
          if (mv_en_r) st_r <= S_MRD;
          else if (wb_en_r) st_r <= S_WB;
          else st_r <= S_RESP;
        end
        // table move, one read and one write per entry
        S_MRD: st_r <= S_MWR;
        S_MWR: begin
          if (mv_src_r == mv_end_r) st_r <= wb_en_r ? S_WB : S_RESP;
          else begin
            mv_src_r <= mv_up_r ? mv_src_r - CW'(1) : mv_src_r + CW'(1);
            st_r     <= S_MRD;
          end
        end
        S_WB: st_r <= S_RESP;
        // hand the result to the output register
        S_RESP: if (out_load) begin
          oaddr_r <= raddr_r;
          ostat_r <= stat_r;
          oseg_r  <= top_r;
          ofree_r <= ftot_r;
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a waiting result beat holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_addr)
      && $stable(out_ch.status) && $stable(out_ch.segment_bytes)
      && $stable(out_ch.free_bytes));
  // the table never holds more entries than its depth
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXC);
  // free bytes never exceed the segment
  a_free_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.free_bytes <= out_ch.segment_bytes);
`endif

endmodule
